FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file of the sender window block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on a rising clock, off while reset is low.
`define SRSW_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sender window check failed");

// Same, for a property that must also hold while reset is low.
`define SRSW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sender window check failed");

`endif

FILE: rtl/core/srsw_pkg.sv
// Package of the selective-repeat sender window: word types, codes, fixed widths.
// No dependencies; the files that use it refer to it by scoped names.
package srsw_pkg;

  localparam int FRAME_NUM_W = 16;  // frame numbers and counters
  localparam int WIN_W       = 4;   // window_size register
  localparam int ACK_BITS    = 8;   // one outcome bit per slot
  localparam int SLOT_W      = 3;   // slot index, below ACK_BITS
  localparam int CFG_DATA_W  = 16;
  localparam int CMDQ_DEPTH  = 2;
  localparam int OUTQ_DEPTH  = 4;

  localparam logic [0:0] REG_FRAME_TOTAL = 1'b0;
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ROUND = 1'b1;

  typedef enum logic [2:0] {
    EV_SENT  = 3'd0,
    EV_ACK   = 3'd1,
    EV_FAIL  = 3'd2,
    EV_START = 3'd3,
    EV_DONE  = 3'd4
  } event_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_REPORT,
    ST_COMPACT,
    ST_FLUSH
  } back_state_e;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic                is_round;
    logic [ACK_BITS-1:0] fails;
    logic [SLOT_W-1:0]   last_slot;
  } cmd_t;

  // One result word.
  typedef struct packed {
    event_kind_e            kind;
    logic [FRAME_NUM_W-1:0] frame;
    logic                   last;
  } res_t;

endpackage

FILE: rtl/core/srsw_fifo.sv
// Small first-word-fall-through queue of flip-flops, used on both sides of the back.
// No package dependency.
module srsw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : AW'(wr_q + 1'b1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : AW'(rd_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/srsw_front.sv
// Front of the sender window: takes input words, classifies them, queues them.
// Depends on srsw_pkg and srsw_fifo.
module srsw_front #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic                                command_i,
  input  logic [srsw_pkg::ACK_BITS-1:0]       ack_fail_bits_i,
  input  logic [srsw_pkg::WIN_W-1:0]          window_size_i,
  output logic                                full_o,
  output logic                                cmd_valid_o,
  output srsw_pkg::cmd_t                      cmd_o,
  input  logic                                cmd_pop_i
);

  localparam int SLOT_CAP = (WINDOW_DEPTH < srsw_pkg::ACK_BITS) ?
                            WINDOW_DEPTH : srsw_pkg::ACK_BITS;

  logic [srsw_pkg::WIN_W-1:0]                  eff_win;
  srsw_pkg::cmd_t                              cls;
  logic                                        q_empty;
  logic [$bits(srsw_pkg::cmd_t)-1:0]           q_data;

  // Clamp the window: zero acts as one, saturate at the slot cap.
  always_comb begin
    if (window_size_i == '0) begin
      eff_win = srsw_pkg::WIN_W'(1);
    end else if (window_size_i > srsw_pkg::WIN_W'(SLOT_CAP)) begin
      eff_win = srsw_pkg::WIN_W'(SLOT_CAP);
    end else begin
      eff_win = window_size_i;
    end
    cls.is_round  = (command_i == srsw_pkg::CMD_ROUND);
    cls.fails     = ack_fail_bits_i;
    cls.last_slot = srsw_pkg::SLOT_W'(eff_win - srsw_pkg::WIN_W'(1));
  end

  srsw_fifo #(
    .WIDTH ($bits(srsw_pkg::cmd_t)),
    .DEPTH (srsw_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = srsw_pkg::cmd_t'(q_data);

endmodule

FILE: rtl/core/srsw_back.sv
// Back of the sender window: slot sequencer, transfer counters, retransmit list.
// Depends on srsw_pkg.
module srsw_back #(
  parameter int WINDOW_DEPTH = 8,
  parameter int FRAME_BITS   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [srsw_pkg::FRAME_NUM_W-1:0]    frame_total_i,
  input  logic                                cmd_valid_i,
  input  srsw_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output srsw_pkg::res_t                      res_o
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int FW    = srsw_pkg::FRAME_NUM_W;

  srsw_pkg::back_state_e             state_q, state_d;
  logic [srsw_pkg::SLOT_W-1:0]       slot_q, slot_d, last_slot_q, last_slot_d;
  logic [srsw_pkg::ACK_BITS-1:0]     fails_q, fails_d;
  logic [FW-1:0]                     hs_q, hs_d, hr_q, hr_d, acked_q, acked_d;
  logic [CW-1:0]                     ip_q, ip_d, keep_q, keep_d;
  logic [IDX_W-1:0]                  sweep_q, sweep_d;
  logic                              pend_valid_q, pend_valid_d;
  srsw_pkg::res_t                    pend_q, pend_d;

  logic [FRAME_BITS-1:0]             list_q [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]           valid_q;

  logic                              list_we;
  logic [IDX_W-1:0]                  list_wa;
  logic [FRAME_BITS-1:0]             list_wd;
  logic                              vset, vclr, vclr_all;
  logic [IDX_W-1:0]                  vset_idx;

  logic [31:0]                       slot_wide, rd_wide, new_wide;
  logic [IDX_W-1:0]                  slot_idx, rd_idx;
  logic                              rd_valid;
  logic [FRAME_BITS-1:0]             rd_entry;
  logic [FW-1:0]                     rd_frame, new_frame;
  logic [srsw_pkg::ACK_BITS-1:0]     fail_sh;
  logic                              fail_bit;
  logic                              emit;
  srsw_pkg::res_t                    emit_res;

  assign slot_wide = 32'(slot_q);
  assign slot_idx  = slot_wide[IDX_W-1:0];
  assign rd_idx    = (state_q == srsw_pkg::ST_COMPACT) ? sweep_q : slot_idx;
  assign rd_valid  = valid_q[rd_idx];
  assign rd_entry  = list_q[rd_idx];
  assign rd_wide   = 32'(rd_entry);
  assign rd_frame  = rd_wide[FW-1:0];
  assign fail_sh   = fails_q >> slot_q;
  assign fail_bit  = fail_sh[0];
  assign new_frame = (state_q == srsw_pkg::ST_SEND) ? FW'(hs_q + 1'b1) : FW'(hr_q + 1'b1);
  assign new_wide  = 32'(new_frame);

  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    last_slot_d  = last_slot_q;
    fails_d      = fails_q;
    hs_d         = hs_q;
    hr_d         = hr_q;
    acked_d      = acked_q;
    ip_d         = ip_q;
    keep_d       = keep_q;
    sweep_d      = sweep_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_o        = '{kind: pend_q.kind, frame: pend_q.frame, last: 1'b0};
    list_we      = 1'b0;
    list_wa      = ip_q[IDX_W-1:0];
    list_wd      = new_wide[FRAME_BITS-1:0];
    vset         = 1'b0;
    vset_idx     = ip_q[IDX_W-1:0];
    vclr         = 1'b0;
    vclr_all     = 1'b0;
    emit         = 1'b0;
    emit_res     = '{kind: srsw_pkg::EV_SENT, frame: new_frame, last: 1'b0};

    case (state_q)
      srsw_pkg::ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          if (!cmd_i.is_round) begin
            res_push_o = 1'b1;
            res_o      = '{kind: srsw_pkg::EV_START, frame: '0, last: 1'b1};
            hs_d       = '0;
            hr_d       = '0;
            acked_d    = '0;
            ip_d       = '0;
            vclr_all   = 1'b1;
          end else if (acked_q >= frame_total_i) begin
            res_push_o = 1'b1;
            res_o      = '{kind: srsw_pkg::EV_DONE, frame: '0, last: 1'b1};
          end else begin
            fails_d     = cmd_i.fails;
            last_slot_d = cmd_i.last_slot;
            slot_d      = '0;
            state_d     = srsw_pkg::ST_SEND;
          end
        end
      end

      srsw_pkg::ST_SEND: begin
        if (!res_full_i) begin
          if (rd_valid) begin
            emit     = 1'b1;
            emit_res = '{kind: srsw_pkg::EV_SENT, frame: rd_frame, last: 1'b0};
          end else if (hs_q < frame_total_i) begin
            hs_d = new_frame;
            emit = 1'b1;
          end
          if (slot_q == last_slot_q) begin
            slot_d  = '0;
            state_d = srsw_pkg::ST_REPORT;
          end else begin
            slot_d = srsw_pkg::SLOT_W'(slot_q + 1'b1);
          end
        end
      end

      srsw_pkg::ST_REPORT: begin
        if (acked_q >= frame_total_i) begin
          sweep_d = '0;
          keep_d  = '0;
          state_d = srsw_pkg::ST_COMPACT;
        end else if (!res_full_i) begin
          if (rd_valid) begin
            emit = 1'b1;
            if (!fail_bit) begin
              vclr     = 1'b1;
              acked_d  = FW'(acked_q + 1'b1);
              emit_res = '{kind: srsw_pkg::EV_ACK, frame: rd_frame, last: 1'b0};
            end else begin
              emit_res = '{kind: srsw_pkg::EV_FAIL, frame: rd_frame, last: 1'b0};
            end
          end else if (hr_q < frame_total_i) begin
            hr_d = new_frame;
            emit = 1'b1;
            if (!fail_bit) begin
              acked_d  = FW'(acked_q + 1'b1);
              emit_res = '{kind: srsw_pkg::EV_ACK, frame: new_frame, last: 1'b0};
            end else begin
              // Append the failed frame to the retransmit list while it has room.
              if (ip_q < CW'(WINDOW_DEPTH)) begin
                list_we = 1'b1;
                vset    = 1'b1;
                ip_d    = CW'(ip_q + 1'b1);
              end
              emit_res = '{kind: srsw_pkg::EV_FAIL, frame: new_frame, last: 1'b0};
            end
          end
          if (slot_q == last_slot_q) begin
            sweep_d = '0;
            keep_d  = '0;
            state_d = srsw_pkg::ST_COMPACT;
          end else begin
            slot_d = srsw_pkg::SLOT_W'(slot_q + 1'b1);
          end
        end
      end

      srsw_pkg::ST_COMPACT: begin
        // Move each live entry down to the next free place, one entry a cycle.
        if (rd_valid) begin
          list_we  = 1'b1;
          list_wa  = keep_q[IDX_W-1:0];
          list_wd  = rd_entry;
          vclr     = 1'b1;
          vset     = 1'b1;
          vset_idx = keep_q[IDX_W-1:0];
          keep_d   = CW'(keep_q + 1'b1);
        end
        if (sweep_q == IDX_W'(WINDOW_DEPTH - 1)) begin
          ip_d    = keep_d;
          state_d = srsw_pkg::ST_FLUSH;
        end else begin
          sweep_d = IDX_W'(sweep_q + 1'b1);
        end
      end

      srsw_pkg::ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = srsw_pkg::ST_IDLE;
        end else if (!res_full_i) begin
          res_push_o   = 1'b1;
          res_o        = '{kind: pend_q.kind, frame: pend_q.frame, last: 1'b1};
          pend_valid_d = 1'b0;
          state_d      = srsw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = srsw_pkg::ST_IDLE;
      end
    endcase

    // Hold back one result so the final one of a round can carry its mark.
    if (emit) begin
      if (pend_valid_q) begin
        res_push_o = 1'b1;
      end
      pend_d       = emit_res;
      pend_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= srsw_pkg::ST_IDLE;
      slot_q       <= '0;
      last_slot_q  <= '0;
      fails_q      <= '0;
      hs_q         <= '0;
      hr_q         <= '0;
      acked_q      <= '0;
      ip_q         <= '0;
      keep_q       <= '0;
      sweep_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_q       <= slot_d;
      last_slot_q  <= last_slot_d;
      fails_q      <= fails_d;
      hs_q         <= hs_d;
      hr_q         <= hr_d;
      acked_q      <= acked_d;
      ip_q         <= ip_d;
      keep_q       <= keep_d;
      sweep_q      <= sweep_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  // Valid marks: a set wins over a clear at the same place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (vclr_all) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (vclr && (rd_idx == IDX_W'(i))) begin
          valid_q[i] <= 1'b0;
        end
        if (vset && (vset_idx == IDX_W'(i))) begin
          valid_q[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_q[list_wa] <= list_wd;
    end
  end

endmodule

FILE: rtl/core/selective_repeat_sender_window.sv
// Selective-repeat sender window. Push command words (start a transfer, or run one
// round with one ack-failure bit per slot) and pop event words: frames sent in slot
// order, then one acked/failed report per slot, last_of_round_o marking the final
// word each command causes. The front classifies each command and queues up to two
// of them, so it keeps taking words while the back works; the back runs a sequencer
// that handles one slot per cycle and feeds a four-word result queue. A start or a
// round after completion is answered straight from the idle state; a round runs the
// slot sequencer (send pass, then report pass), then the compaction sweep that goes
// over every retransmit list entry once. A full result queue stalls the back. Frame
// numbers run from 1 to frame_total; entries of the retransmit list are FRAME_BITS
// wide.
// Depends on srsw_pkg, srsw_fifo, srsw_front and srsw_back.
module selective_repeat_sender_window #(
  parameter int WINDOW_DEPTH = 8,
  parameter int FRAME_BITS   = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Command side
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 command_i,
  input  logic [srsw_pkg::ACK_BITS-1:0]        ack_fail_bits_i,
  // Event side
  output logic                                 empty,
  input  logic                                 pop,
  output logic [2:0]                           event_kind_o,
  output logic [srsw_pkg::FRAME_NUM_W-1:0]     frame_number_o,
  output logic                                 last_of_round_o,
  // Register writes
  input  logic                                 cfg_we_i,
  input  logic [0:0]                           cfg_index_i,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic [srsw_pkg::FRAME_NUM_W-1:0]   frame_total_q;
  logic [srsw_pkg::WIN_W-1:0]         window_size_q;

  logic                               cmd_valid, cmd_pop;
  srsw_pkg::cmd_t                     cmd;
  logic                               res_push, res_full;
  srsw_pkg::res_t                     res_in, res_out;
  logic [$bits(srsw_pkg::res_t)-1:0]  outq_data;

  // Registers take effect at once; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_total_q <= srsw_pkg::FRAME_NUM_W'(1);
      window_size_q <= srsw_pkg::WIN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        srsw_pkg::REG_FRAME_TOTAL: frame_total_q <= cfg_data_i[srsw_pkg::FRAME_NUM_W-1:0];
        srsw_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data_i[srsw_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srsw_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .command_i       (command_i),
    .ack_fail_bits_i (ack_fail_bits_i),
    .window_size_i   (window_size_q),
    .full_o          (full),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  srsw_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .FRAME_BITS   (FRAME_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_total_i (frame_total_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  // Result queue: parts the back from the consumer.
  srsw_fifo #(
    .WIDTH ($bits(srsw_pkg::res_t)),
    .DEPTH (srsw_pkg::OUTQ_DEPTH)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (outq_data)
  );

  assign res_out         = srsw_pkg::res_t'(outq_data);
  assign event_kind_o    = res_out.kind;
  assign frame_number_o  = res_out.frame;
  assign last_of_round_o = res_out.last;

endmodule

FILE: rtl/core/srsw_checker.sv
// Port-level checks of the sender window, bound to the top level.
// Depends on srsw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  event_kind_o,
  input logic [15:0] frame_number_o,
  input logic        last_of_round_o
);

  // A waiting word that is not taken stays put.
  `SRSW_ASSERT(a_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(event_kind_o) && $stable(frame_number_o))

  // Only the five event codes appear.
  `SRSW_ASSERT(a_kind, clk_i, rst_ni, !empty |-> event_kind_o <= srsw_pkg::EV_DONE)

  // Start and complete words stand alone and name no frame.
  `SRSW_ASSERT(a_single, clk_i, rst_ni, !empty && (event_kind_o == srsw_pkg::EV_START || event_kind_o == srsw_pkg::EV_DONE) |-> last_of_round_o && frame_number_o == '0)

  // Sent and report words always name a frame from one up.
  `SRSW_ASSERT(a_frame, clk_i, rst_ni, !empty && event_kind_o <= srsw_pkg::EV_FAIL |-> frame_number_o != '0)

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for selective_repeat_sender_window: drives command words and
// register writes and checks every event word against an in-bench window predictor.
// Depends on srsw_pkg and the block's RTL only.
module tb_top;

  localparam int WINDOW_DEPTH = 8;
  localparam int FRAME_BITS   = 16;
  localparam int ACK_BITS     = srsw_pkg::ACK_BITS;
  localparam int FRAME_NUM_W  = srsw_pkg::FRAME_NUM_W;
  localparam int WIN_W        = srsw_pkg::WIN_W;
  localparam int CFG_DATA_W   = srsw_pkg::CFG_DATA_W;
  // Clamped slot count: the window can never use more slots than there are ack bits.
  localparam int SLOT_LIMIT   = (WINDOW_DEPTH < ACK_BITS) ? WINDOW_DEPTH : ACK_BITS;
  // Room for the back to finish a round and its compaction sweep; leave margin.
  localparam int SETTLE_CYCLES = 4 * SLOT_LIMIT + WINDOW_DEPTH + 8;
  localparam int RANDOM_ITEMS  = 200;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_ROUNDS   = 16;

  // Predicts the event words of the sender window and holds the ones still due.
  class sender_window_board;
    srsw_pkg::res_t        events_due[$];
    int                    mismatches;
    int unsigned           frame_total;
    int unsigned           window_size;
    int unsigned           highest_sent;
    int unsigned           highest_reported;
    int unsigned           acked_count;
    int unsigned           insert_point;
    logic [FRAME_BITS-1:0] resend_frame [WINDOW_DEPTH];
    bit                    resend_valid [WINDOW_DEPTH];

    function new();
      frame_total = 1;
      window_size = 1;
      mismatches  = 0;
      restart();
    endfunction

    function void restart();
      highest_sent     = 0;
      highest_reported = 0;
      acked_count      = 0;
      insert_point     = 0;
      for (int s = 0; s < WINDOW_DEPTH; s++) begin
        resend_frame[s] = '0;
        resend_valid[s] = 1'b0;
      end
    endfunction

    function void set_reg(logic [0:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == srsw_pkg::REG_FRAME_TOTAL) begin
        frame_total = val[FRAME_NUM_W-1:0];
      end else begin
        window_size = val[WIN_W-1:0];
      end
    endfunction

    function void post(srsw_pkg::event_kind_e kind, int unsigned frame);
      srsw_pkg::res_t word;
      word.kind  = kind;
      word.frame = FRAME_NUM_W'(frame);
      word.last  = 1'b0;
      events_due.push_back(word);
    endfunction

    // Move the surviving retransmit entries to the front, in order.
    function void compact();
      int unsigned k;
      k = 0;
      for (int s = 0; s < WINDOW_DEPTH; s++) begin
        if (resend_valid[s]) begin
          resend_frame[k] = resend_frame[s];
          resend_valid[k] = 1'b1;
          k++;
        end
      end
      for (int s = k; s < WINDOW_DEPTH; s++) resend_valid[s] = 1'b0;
      insert_point = k;
    endfunction

    // Work out the events of one accepted command word.
    function void note_command(logic cmd, logic [ACK_BITS-1:0] fails);
      int unsigned    w;
      int unsigned    frame;
      int             before_cnt;
      srsw_pkg::res_t tail;
      before_cnt = events_due.size();
      if (cmd == srsw_pkg::CMD_START) begin
        restart();
        post(srsw_pkg::EV_START, 0);
      end else if (acked_count >= frame_total) begin
        post(srsw_pkg::EV_DONE, 0);
      end else begin
        w = window_size;
        if (w < 1) w = 1;
        if (w > SLOT_LIMIT) w = SLOT_LIMIT;
        // Send pass: listed frames first, then fresh ones while any are left.
        for (int s = 0; s < w; s++) begin
          if (resend_valid[s]) begin
            post(srsw_pkg::EV_SENT, resend_frame[s]);
          end else if (highest_sent < frame_total) begin
            highest_sent++;
            post(srsw_pkg::EV_SENT, highest_sent);
          end
        end
        // Report pass: stops as soon as the whole transfer is acknowledged.
        for (int s = 0; s < w && acked_count < frame_total; s++) begin
          if (resend_valid[s]) begin
            if (!fails[s]) begin
              resend_valid[s] = 1'b0;
              acked_count++;
              post(srsw_pkg::EV_ACK, resend_frame[s]);
            end else begin
              post(srsw_pkg::EV_FAIL, resend_frame[s]);
            end
          end else begin
            if (highest_reported >= frame_total) continue;
            highest_reported++;
            frame = highest_reported;
            if (!fails[s]) begin
              acked_count++;
              post(srsw_pkg::EV_ACK, frame);
            end else begin
              if (insert_point < WINDOW_DEPTH) begin
                resend_frame[insert_point] = FRAME_BITS'(frame);
                resend_valid[insert_point] = 1'b1;
                insert_point++;
              end
              post(srsw_pkg::EV_FAIL, frame);
            end
          end
        end
        compact();
      end
      // Flag the final word of this command, if it caused any.
      if (events_due.size() > before_cnt) begin
        tail = events_due.pop_back();
        tail.last = 1'b1;
        events_due.push_back(tail);
      end
    endfunction

    function void check_event(logic [2:0] kind, logic [FRAME_NUM_W-1:0] frame, logic last);
      srsw_pkg::res_t due;
      if (events_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual kind %0d frame %0d last %0d",
                 $time, kind, frame, last);
        return;
      end
      due = events_due.pop_front();
      if (kind !== due.kind) begin
        mismatches++;
        $display("%0t: event kind expected %0d actual %0d", $time, due.kind, kind);
      end
      if (frame !== due.frame) begin
        mismatches++;
        $display("%0t: frame number expected %0d actual %0d", $time, due.frame, frame);
      end
      if (last !== due.last) begin
        mismatches++;
        $display("%0t: last of round expected %0d actual %0d", $time, due.last, last);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic                   command_i;
  logic [ACK_BITS-1:0]    ack_fail_bits_i;
  logic                   empty;
  logic                   pop;
  logic [2:0]             event_kind_o;
  logic [FRAME_NUM_W-1:0] frame_number_o;
  logic                   last_of_round_o;
  logic                   cfg_we_i;
  logic [0:0]             cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  sender_window_board sb;
  bit                 no_idle;    // final stretch: both sides run flat out
  int                 hold_left;  // receiver hold-off, counted down by the receiver

  selective_repeat_sender_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .FRAME_BITS  (FRAME_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .ack_fail_bits_i(ack_fail_bits_i),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind_o),
    .frame_number_o (frame_number_o),
    .last_of_round_o(last_of_round_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: check each popped word, then decide whether to pop next cycle.
  // Idle in short random bursts, or hold off entirely while hold_left runs down.
  initial begin
    int gap_left;
    gap_left = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) sb.check_event(event_kind_o, frame_number_o, last_of_round_o);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        pop <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 3) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offer one command word and hold it until the block takes it. An idle burst may
  // come first; push stays high across back-to-back words.
  task automatic send_word(logic cmd, logic [ACK_BITS-1:0] fails);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    push            <= 1'b1;
    command_i       <= cmd;
    ack_fail_bits_i <= fails;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_command(cmd, fails);
  endtask

  // Stop offering, wait for every due word, then let the back finish compaction.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.events_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Ack-failure pattern; bias 2 fails half the slots, the others fewer, so transfers can finish.
  function automatic logic [ACK_BITS-1:0] fail_pattern(int unsigned bias);
    logic [ACK_BITS-1:0] a;
    logic [ACK_BITS-1:0] b;
    a = ACK_BITS'($urandom);
    b = ACK_BITS'($urandom);
    case (bias)
      0: return a & b & ACK_BITS'($urandom);
      1: return a & b;
      2: return a;
      default: return ($urandom_range(0, 3) == 0) ? (a & b) : '0;
    endcase
  endfunction

  initial begin
    int                     rand_items;
    int                     phase;
    int                     rounds;
    int unsigned            bias;
    logic [FRAME_NUM_W-1:0] total_val;
    logic [WIN_W-1:0]       win_val;

    sb              = new();
    no_idle         = 1'b0;
    hold_left       = 0;
    rst_ni          <= 1'b0;
    push            <= 1'b0;
    command_i       <= srsw_pkg::CMD_START;
    ack_fail_bits_i <= '0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= srsw_pkg::REG_FRAME_TOTAL;
    cfg_data_i      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: one frame, one slot. Fail it, resend it, then complete.
    send_word(srsw_pkg::CMD_ROUND, 8'h01);
    send_word(srsw_pkg::CMD_ROUND, 8'h00);
    send_word(srsw_pkg::CMD_ROUND, 8'h00);
    send_word(srsw_pkg::CMD_START, 8'hFF);

    // Window of zero acts as a single slot.
    settle();
    write_reg(srsw_pkg::REG_FRAME_TOTAL, 16'd20);
    write_reg(srsw_pkg::REG_WINDOW_SIZE, 16'd0);
    send_word(srsw_pkg::CMD_ROUND, 8'hFE);
    send_word(srsw_pkg::CMD_ROUND, 8'h01);

    // Window above the ack width saturates to eight slots.
    settle();
    write_reg(srsw_pkg::REG_WINDOW_SIZE, 16'd15);
    send_word(srsw_pkg::CMD_ROUND, 8'hFF);
    send_word(srsw_pkg::CMD_ROUND, 8'h5A);
    send_word(srsw_pkg::CMD_ROUND, 8'h00);
    send_word(srsw_pkg::CMD_ROUND, 8'h81);

    // Window wider than the transfer: empty slots skipped, reports stop early.
    settle();
    write_reg(srsw_pkg::REG_FRAME_TOTAL, 16'd5);
    write_reg(srsw_pkg::REG_WINDOW_SIZE, 16'd8);
    send_word(srsw_pkg::CMD_START, 8'h00);
    send_word(srsw_pkg::CMD_ROUND, 8'h24);
    send_word(srsw_pkg::CMD_ROUND, 8'hFF);
    send_word(srsw_pkg::CMD_ROUND, 8'h00);
    send_word(srsw_pkg::CMD_ROUND, 8'h00);

    // Zero frames: a round reports completion at once.
    settle();
    write_reg(srsw_pkg::REG_FRAME_TOTAL, 16'd0);
    send_word(srsw_pkg::CMD_ROUND, 8'h00);

    // Largest transfer, then lower the total below the counters mid-transfer.
    settle();
    write_reg(srsw_pkg::REG_FRAME_TOTAL, 16'hFFFF);
    send_word(srsw_pkg::CMD_START, 8'h00);
    send_word(srsw_pkg::CMD_ROUND, 8'hFF);
    send_word(srsw_pkg::CMD_ROUND, 8'h55);
    send_word(srsw_pkg::CMD_ROUND, 8'h00);
    settle();
    write_reg(srsw_pkg::REG_FRAME_TOTAL, 16'd3);
    send_word(srsw_pkg::CMD_ROUND, 8'h00);

    // Random transfers: mostly start then rounds, small totals, varied failure rates.
    rand_items = 0;
    phase      = 0;
    while (rand_items < RANDOM_ITEMS) begin
      phase++;
      settle();
      case ($urandom_range(0, 19))
        0:       total_val = '0;
        1:       total_val = '1;
        2:       total_val = 16'd1;
        default: total_val = FRAME_NUM_W'($urandom_range(2, 40));
      endcase
      win_val = WIN_W'($urandom_range(0, 15));
      write_reg(srsw_pkg::REG_FRAME_TOTAL, total_val);
      if ($urandom_range(0, 3) == 0)
        write_reg(srsw_pkg::REG_WINDOW_SIZE, {12'($urandom_range(0, 4095)), win_val});
      else
        write_reg(srsw_pkg::REG_WINDOW_SIZE, {12'd0, win_val});
      no_idle = (rand_items >= RANDOM_ITEMS - 40);
      bias    = $urandom_range(0, 3);
      if ($urandom_range(0, 9) != 0) begin
        send_word(srsw_pkg::CMD_START, ACK_BITS'($urandom));
        rand_items++;
      end
      rounds = $urandom_range(3, 16);
      // Hold the receiver off so both queues fill and push stalls.
      if (phase == 2) begin
        hold_left = LONG_HOLD;
        rounds    = HOLD_ROUNDS;
      end
      for (int k = 0; k < rounds; k++) begin
        // Pause the sender until every due word has drained.
        if (phase == 4 && k == rounds / 2) begin
          push <= 1'b0;
          @(posedge clk_i);
          while (sb.events_due.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 19) == 0)
          send_word(srsw_pkg::CMD_START, ACK_BITS'($urandom));
        else
          send_word(srsw_pkg::CMD_ROUND, fail_pattern(bias));
        rand_items++;
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.events_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
